>>> rtl/apt_pkg.sv
// shared types and constants for the affine point transform core
// no dependencies; imported by apt_cfg_regs, apt_row_pipe and the top level
package apt_pkg;

	// default field widths
	localparam int DEF_COORD_WIDTH    = 32;
	localparam int DEF_COEF_WIDTH     = 16;
	localparam int DEF_COEF_FRAC_BITS = 12;

	// pipeline depth: multiply, round, sum, saturate
	localparam int NUM_STAGES = 4;

	// register map: eight bytes per register
	localparam int NUM_REGS   = 6;
	localparam int REG_STRIDE = 8;
	localparam int ADDR_W     = $clog2(NUM_REGS * REG_STRIDE);
	localparam int IDX_LSB    = $clog2(REG_STRIDE);
	localparam int IDX_W      = ADDR_W - IDX_LSB;

	typedef logic [IDX_W-1:0] reg_idx_t;

	localparam reg_idx_t REG_ROW0    = reg_idx_t'(0);
	localparam reg_idx_t REG_ROW1    = reg_idx_t'(1);
	localparam reg_idx_t REG_ROW2    = reg_idx_t'(2);
	localparam reg_idx_t REG_SHIFT_X = reg_idx_t'(3);
	localparam reg_idx_t REG_SHIFT_Y = reg_idx_t'(4);
	localparam reg_idx_t REG_SHIFT_Z = reg_idx_t'(5);

	// per-stage load enables plus the point flag lined up with the sum stage
	typedef struct packed {
		logic [NUM_STAGES-1:0] en;
		logic                  point_s2;
	} pipe_ctl_t;

endpackage

>>> rtl/apt_cfg_regs.sv
// register file for the matrix rows and translations, apb-style access
// depends on apt_pkg for the register map
module apt_cfg_regs #(
	parameter int COORD_WIDTH    = apt_pkg::DEF_COORD_WIDTH,
	parameter int COEF_WIDTH     = apt_pkg::DEF_COEF_WIDTH,
	parameter int COEF_FRAC_BITS = apt_pkg::DEF_COEF_FRAC_BITS,
	parameter int DATA_W         = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [apt_pkg::ADDR_W-1:0]    paddr,
	input  logic [DATA_W-1:0]             pwdata,
	output logic [DATA_W-1:0]             prdata,
	output logic                          pready,
	output logic [3*COEF_WIDTH-1:0]       row_q [3],
	output logic [COORD_WIDTH-1:0]        shift_q [3]
);
	import apt_pkg::*;

	localparam int ROW_W = 3 * COEF_WIDTH;

	reg_idx_t idx;
	logic     wr_en;

	assign pready = 1'b1;
	assign idx    = paddr[ADDR_W-1:IDX_LSB];
	assign wr_en  = psel & penable & pwrite & pready;

	// register writes, reset to the identity transform
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < 3; r++) begin
				row_q[r]   <= (ROW_W'(1) << COEF_FRAC_BITS) << (r * COEF_WIDTH);
				shift_q[r] <= '0;
			end
		end else if (wr_en) begin
			unique case (idx)
				REG_ROW0:    row_q[0]   <= pwdata[ROW_W-1:0];
				REG_ROW1:    row_q[1]   <= pwdata[ROW_W-1:0];
				REG_ROW2:    row_q[2]   <= pwdata[ROW_W-1:0];
				REG_SHIFT_X: shift_q[0] <= pwdata[COORD_WIDTH-1:0];
				REG_SHIFT_Y: shift_q[1] <= pwdata[COORD_WIDTH-1:0];
				REG_SHIFT_Z: shift_q[2] <= pwdata[COORD_WIDTH-1:0];
				default: ;
			endcase
		end
	end

	// read back
	always_comb begin
		unique case (idx)
			REG_ROW0:    prdata = DATA_W'(row_q[0]);
			REG_ROW1:    prdata = DATA_W'(row_q[1]);
			REG_ROW2:    prdata = DATA_W'(row_q[2]);
			REG_SHIFT_X: prdata = DATA_W'(shift_q[0]);
			REG_SHIFT_Y: prdata = DATA_W'(shift_q[1]);
			REG_SHIFT_Z: prdata = DATA_W'(shift_q[2]);
			default:     prdata = '0;
		endcase
	end

endmodule

>>> rtl/apt_row_pipe.sv
// datapath for one output coordinate: multiply, round, sum, saturate
// depends on apt_pkg for the pipeline control struct
module apt_row_pipe #(
	parameter int COORD_WIDTH    = apt_pkg::DEF_COORD_WIDTH,
	parameter int COEF_WIDTH     = apt_pkg::DEF_COEF_WIDTH,
	parameter int COEF_FRAC_BITS = apt_pkg::DEF_COEF_FRAC_BITS
) (
	input  logic                          clk,
	input  apt_pkg::pipe_ctl_t            ctl,
	input  logic [3*COEF_WIDTH-1:0]       row,
	input  logic signed [COORD_WIDTH-1:0] shift,
	input  logic signed [COORD_WIDTH-1:0] x,
	input  logic signed [COORD_WIDTH-1:0] y,
	input  logic signed [COORD_WIDTH-1:0] z,
	output logic signed [COORD_WIDTH-1:0] coord_s4,
	output logic                          sat_s4
);
	import apt_pkg::*;

	localparam int PROD_W = COORD_WIDTH + COEF_WIDTH;
	localparam int SUM_W  = PROD_W + 2;

	localparam logic signed [PROD_W-1:0] HALF   = PROD_W'(1) << (COEF_FRAC_BITS - 1);
	localparam logic signed [SUM_W-1:0]  SAT_HI = (SUM_W'(1) << (COORD_WIDTH - 1)) - SUM_W'(1);
	localparam logic signed [SUM_W-1:0]  SAT_LO = -(SUM_W'(1) << (COORD_WIDTH - 1));

	logic signed [COEF_WIDTH-1:0]  coef [3];
	logic signed [COORD_WIDTH-1:0] coord [3];
	logic signed [PROD_W-1:0]      prod_s1 [3];
	logic signed [PROD_W-1:0]      rnd_s2 [3];
	logic signed [SUM_W-1:0]       sum_s3;
	logic signed [SUM_W-1:0]       offset;

	always_comb begin
		for (int c = 0; c < 3; c++)
			coef[c] = row[c*COEF_WIDTH +: COEF_WIDTH];
		coord[0] = x;
		coord[1] = y;
		coord[2] = z;
	end

	// stage 1: exact products
	always_ff @(posedge clk) begin
		if (ctl.en[0]) begin
			for (int c = 0; c < 3; c++)
				prod_s1[c] <= PROD_W'(coef[c]) * PROD_W'(coord[c]);
		end
	end

	// stage 2: round to nearest back to the coordinate scale
	always_ff @(posedge clk) begin
		if (ctl.en[1]) begin
			for (int c = 0; c < 3; c++)
				rnd_s2[c] <= (prod_s1[c] + HALF) >>> COEF_FRAC_BITS;
		end
	end

	// stage 3: exact sum, translation only for points
	assign offset = ctl.point_s2 ? SUM_W'(shift) : '0;

	always_ff @(posedge clk) begin
		if (ctl.en[2])
			sum_s3 <= SUM_W'(rnd_s2[0]) + SUM_W'(rnd_s2[1]) + SUM_W'(rnd_s2[2]) + offset;
	end

	// stage 4: clip to the coordinate range
	always_ff @(posedge clk) begin
		if (ctl.en[3]) begin
			if (sum_s3 > SAT_HI) begin
				coord_s4 <= SAT_HI[COORD_WIDTH-1:0];
				sat_s4   <= 1'b1;
			end else if (sum_s3 < SAT_LO) begin
				coord_s4 <= SAT_LO[COORD_WIDTH-1:0];
				sat_s4   <= 1'b1;
			end else begin
				coord_s4 <= sum_s3[COORD_WIDTH-1:0];
				sat_s4   <= 1'b0;
			end
		end
	end

endmodule

>>> rtl/affine_point_transform_core.sv
// top level of the affine point transform core: handshake control and valid pipeline
// depends on apt_pkg, apt_cfg_regs and apt_row_pipe
//
// Usage: a request on the input channel (in_valid, x_in, y_in, z_in, is_point)
// is taken at a rising edge with in_valid high and in_stall low. Each request
// gives exactly one result on the output channel (out_valid, x_out, y_out,
// z_out, saturated), taken at an edge with out_valid high and out_stall low.
// Each result passes through the multiply, round, sum with translation and saturate stages.
// Throughput is one request per cycle while out_stall is low; the nine coefficient-by-coordinate
// multipliers, one per matrix entry, set that figure.
// When out_stall is held, each stage holds its data while any empty stage
// ahead of it still fills, so up to four requests are held; in_stall rises
// only once the pipeline is full. A held result does not change.
// After arst_n the pipeline is empty and the registers hold the identity
// transform with zero translation. The user must write the matrix and translations
// through the apb-style port (eight bytes per register) only while no request is
// in flight; the block does not enforce this. pready is always high.
module affine_point_transform_core #(
	parameter int COORD_WIDTH    = apt_pkg::DEF_COORD_WIDTH,
	parameter int COEF_WIDTH     = apt_pkg::DEF_COEF_WIDTH,
	parameter int COEF_FRAC_BITS = apt_pkg::DEF_COEF_FRAC_BITS,
	localparam int ROW_W         = 3 * COEF_WIDTH,
	localparam int DATA_W        = (ROW_W > 64) ? ROW_W : 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// configuration
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [apt_pkg::ADDR_W-1:0]    paddr,
	input  logic [DATA_W-1:0]             pwdata,
	output logic [DATA_W-1:0]             prdata,
	output logic                          pready,
	// input channel
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic signed [COORD_WIDTH-1:0] x_in,
	input  logic signed [COORD_WIDTH-1:0] y_in,
	input  logic signed [COORD_WIDTH-1:0] z_in,
	input  logic                          is_point,
	// output channel
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic signed [COORD_WIDTH-1:0] x_out,
	output logic signed [COORD_WIDTH-1:0] y_out,
	output logic signed [COORD_WIDTH-1:0] z_out,
	output logic                          saturated
);
	import apt_pkg::*;

	logic [ROW_W-1:0]              row_q [3];
	logic [COORD_WIDTH-1:0]        shift_q [3];
	logic [NUM_STAGES-1:0]         vld_s;
	logic                          point_s1;
	logic                          point_s2;
	pipe_ctl_t                     ctl;
	logic signed [COORD_WIDTH-1:0] coord_s4 [3];
	logic [2:0]                    sat_s4;

	// configuration registers
	apt_cfg_regs #(
		.COORD_WIDTH    (COORD_WIDTH),
		.COEF_WIDTH     (COEF_WIDTH),
		.COEF_FRAC_BITS (COEF_FRAC_BITS),
		.DATA_W         (DATA_W)
	) u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.row_q   (row_q),
		.shift_q (shift_q)
	);

	// stage enables: a stage loads when it is empty or the next one moves
	always_comb begin
		ctl.en[NUM_STAGES-1] = !vld_s[NUM_STAGES-1] || !out_stall;
		for (int s = NUM_STAGES - 2; s >= 0; s--)
			ctl.en[s] = !vld_s[s] || ctl.en[s+1];
		ctl.point_s2 = point_s2;
	end

	assign in_stall = !ctl.en[0];

	// valid bits travel with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			if (ctl.en[0])
				vld_s[0] <= in_valid;
			for (int s = 1; s < NUM_STAGES; s++) begin
				if (ctl.en[s])
					vld_s[s] <= vld_s[s-1];
			end
		end
	end

	// point flag follows the item up to the sum stage
	always_ff @(posedge clk) begin
		if (ctl.en[0])
			point_s1 <= is_point;
		if (ctl.en[1])
			point_s2 <= point_s1;
	end

	// one datapath per output coordinate
	for (genvar r = 0; r < 3; r++) begin : g_row
		apt_row_pipe #(
			.COORD_WIDTH    (COORD_WIDTH),
			.COEF_WIDTH     (COEF_WIDTH),
			.COEF_FRAC_BITS (COEF_FRAC_BITS)
		) u_row (
			.clk      (clk),
			.ctl      (ctl),
			.row      (row_q[r]),
			.shift    (shift_q[r]),
			.x        (x_in),
			.y        (y_in),
			.z        (z_in),
			.coord_s4 (coord_s4[r]),
			.sat_s4   (sat_s4[r])
		);
	end

	assign out_valid = vld_s[NUM_STAGES-1];
	assign x_out     = coord_s4[0];
	assign y_out     = coord_s4[1];
	assign z_out     = coord_s4[2];
	assign saturated = |sat_s4;

endmodule

>>> tb/apt_tb_pkg.sv
// expected-result book for the affine point transform core: predicts each transformed triple
// depends on apt_pkg for the register indexes and default widths
package apt_tb_pkg;

	import apt_pkg::*;

	localparam int CW       = DEF_COORD_WIDTH;
	localparam int CF       = DEF_COEF_WIDTH;
	localparam int FRAC     = DEF_COEF_FRAC_BITS;
	localparam int ROW_BITS = 3 * CF;

	typedef logic signed [CW-1:0] coord_t;

	// one transformed triple plus its clipping flag
	typedef struct {
		coord_t x;
		coord_t y;
		coord_t z;
		logic   sat;
	} coords_t;

	class coord_transform_book;
		logic [ROW_BITS-1:0] row_coefs[3];
		coord_t              shifts[3];
		coords_t             expected_coords[$];
		int                  errors;
		int                  points;
		int                  vectors;
		int                  clipped;

		// registers come up as the identity with no translation
		function new();
			for (int r = 0; r < 3; r++) begin
				row_coefs[r] = ROW_BITS'(1 << FRAC) << (r * CF);
				shifts[r]    = '0;
			end
			errors  = 0;
			points  = 0;
			vectors = 0;
			clipped = 0;
		endfunction

		// mirror of a register write; high bits beyond the field are dropped
		function void set_register(reg_idx_t idx, logic [63:0] value);
			case (idx)
				REG_ROW0:    row_coefs[0] = value[ROW_BITS-1:0];
				REG_ROW1:    row_coefs[1] = value[ROW_BITS-1:0];
				REG_ROW2:    row_coefs[2] = value[ROW_BITS-1:0];
				REG_SHIFT_X: shifts[0] = value[CW-1:0];
				REG_SHIFT_Y: shifts[1] = value[CW-1:0];
				REG_SHIFT_Z: shifts[2] = value[CW-1:0];
				default: ;
			endcase
		endfunction

		// rounded products summed exactly, translation for points, then clipped
		function coords_t transform_coords(coord_t x, coord_t y, coord_t z, logic pt);
			longint              v[3];
			longint              acc;
			longint              hi;
			longint              lo;
			logic signed [CF-1:0] k;
			coord_t              o[3];
			logic                sat;
			coords_t             res;
			hi   = (longint'(1) <<< (CW - 1)) - 1;
			lo   = -hi - 1;
			v[0] = longint'(x);
			v[1] = longint'(y);
			v[2] = longint'(z);
			sat  = 1'b0;
			for (int r = 0; r < 3; r++) begin
				acc = 0;
				for (int c = 0; c < 3; c++) begin
					k = row_coefs[r][c*CF +: CF];
					acc += (longint'(k) * v[c] + (longint'(1) <<< (FRAC - 1))) >>> FRAC;
				end
				if (pt)
					acc += longint'(shifts[r]);
				if (acc > hi) begin
					acc = hi;
					sat = 1'b1;
				end else if (acc < lo) begin
					acc = lo;
					sat = 1'b1;
				end
				o[r] = acc[CW-1:0];
			end
			res.x   = o[0];
			res.y   = o[1];
			res.z   = o[2];
			res.sat = sat;
			return res;
		endfunction

		function void note_request(coord_t x, coord_t y, coord_t z, logic pt);
			expected_coords.push_back(transform_coords(x, y, z, pt));
			if (pt)
				points++;
			else
				vectors++;
		endfunction

		// compare one delivered triple with the oldest prediction
		function void check_result(coord_t x, coord_t y, coord_t z, logic sat);
			coords_t want;
			if (expected_coords.size() == 0) begin
				$error("unexpected result: x_out %0d y_out %0d z_out %0d saturated %0b",
					x, y, z, sat);
				errors++;
				return;
			end
			want = expected_coords.pop_front();
			if (want.sat)
				clipped++;
			if (x !== want.x) begin
				$error("x_out mismatch: expected %0d, got %0d", want.x, x);
				errors++;
			end
			if (y !== want.y) begin
				$error("y_out mismatch: expected %0d, got %0d", want.y, y);
				errors++;
			end
			if (z !== want.z) begin
				$error("z_out mismatch: expected %0d, got %0d", want.z, z);
				errors++;
			end
			if (sat !== want.sat) begin
				$error("saturated mismatch: expected %0b, got %0b", want.sat, sat);
				errors++;
			end
		endfunction

		function int pending();
			return expected_coords.size();
		endfunction
	endclass

endpackage

>>> tb/affine_point_transform_core_tb.sv
// self-checking bench for affine_point_transform_core: directed corners, then random streams
// depends on apt_pkg, apt_tb_pkg and the core rtl
module affine_point_transform_core_tb;

	import apt_pkg::*;
	import apt_tb_pkg::*;

	localparam coord_t C_MAX = {1'b0, {(CW-1){1'b1}}};
	localparam coord_t C_MIN = {1'b1, {(CW-1){1'b0}}};

	typedef enum logic [1:0] {FLOW, SPARSE_STALL, HEAVY_STALL} stall_mode_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               psel = 1'b0;
	logic               penable = 1'b0;
	logic               pwrite = 1'b0;
	logic [ADDR_W-1:0]  paddr = '0;
	logic [63:0]        pwdata = '0;
	logic [63:0]        prdata;
	logic               pready;
	logic               in_valid = 1'b0;
	logic               in_stall;
	coord_t             x_in = '0;
	coord_t             y_in = '0;
	coord_t             z_in = '0;
	logic               is_point = 1'b0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	coord_t             x_out;
	coord_t             y_out;
	coord_t             z_out;
	logic               saturated;

	coord_transform_book point_book;
	int                  burst_left = 0;
	int                  settings = 0;
	stall_mode_t         stall_mode = FLOW;
	int                  stall_left = 0;

	affine_point_transform_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.x_in      (x_in),
		.y_in      (y_in),
		.z_in      (z_in),
		.is_point  (is_point),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.x_out     (x_out),
		.y_out     (y_out),
		.z_out     (z_out),
		.saturated (saturated)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	// receiver: switches between free flow, light and heavy stalling
	always @(posedge clk) begin
		if (stall_left == 0) begin
			stall_mode <= stall_mode_t'($urandom_range(0, 2));
			stall_left <= $urandom_range(16, 160);
		end else begin
			stall_left <= stall_left - 1;
		end
		case (stall_mode)
			FLOW:         out_stall <= 1'b0;
			SPARSE_STALL: out_stall <= ($urandom_range(0, 3) == 0);
			default:      out_stall <= ($urandom_range(0, 4) != 0);
		endcase
	end

	// every accepted result is checked against the oldest prediction
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			point_book.check_result(x_out, y_out, z_out, saturated);
	end

	// coordinates: full-range, small, medium and corner values
	function automatic coord_t rand_coord();
		coord_t v;
		case ($urandom_range(0, 5))
			0, 1: v = $urandom;
			2:    v = CW'(int'($urandom_range(0, 8191)) - 4096);
			3:    v = CW'(int'($urandom_range(0, 2097151)) - 1048576);
			4: begin
				case ($urandom_range(0, 4))
					0:       v = C_MAX;
					1:       v = C_MIN;
					2:       v = '0;
					3:       v = '1;
					default: v = CW'(1);
				endcase
			end
			default: v = CW'(int'($urandom_range(0, 131071)) - 65536);
		endcase
		return v;
	endfunction

	// coefficients: full-range, near unity, small and corner values
	function automatic logic [CF-1:0] rand_coef();
		logic [CF-1:0] k;
		case ($urandom_range(0, 4))
			0: k = CF'($urandom);
			1: k = CF'(4096 + int'($urandom_range(0, 1023)) - 512);
			2: k = CF'(int'($urandom_range(0, 1023)) - 512);
			3: begin
				case ($urandom_range(0, 4))
					0:       k = 16'h7fff;
					1:       k = 16'h8000;
					2:       k = '0;
					3:       k = 16'hf000;
					default: k = 16'h1000;
				endcase
			end
			default: k = CF'($urandom);
		endcase
		return k;
	endfunction

	// stop sending and let the pipeline empty before any register write
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (point_book.pending() != 0)
			@(posedge clk);
		repeat (NUM_STAGES + 2) @(posedge clk);
	endtask

	// apb write: setup cycle, access cycle, then an idle wait with psel low
	task automatic write_register(reg_idx_t idx, logic [63:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= ADDR_W'(int'(idx) * REG_STRIDE);
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		point_book.set_register(idx, value);
		@(posedge clk);
	endtask

	task automatic load_transform(logic [ROW_BITS-1:0] r0, logic [ROW_BITS-1:0] r1,
			logic [ROW_BITS-1:0] r2, coord_t sx, coord_t sy, coord_t sz);
		wait_idle();
		write_register(REG_ROW0, 64'(r0));
		write_register(REG_ROW1, 64'(r1));
		write_register(REG_ROW2, 64'(r2));
		write_register(REG_SHIFT_X, 64'(sx));
		write_register(REG_SHIFT_Y, 64'(sy));
		write_register(REG_SHIFT_Z, 64'(sz));
		settings++;
	endtask

	// sender: bursts of requests with random gaps between them
	task automatic push_request(coord_t x, coord_t y, coord_t z, logic pt);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		burst_left--;
		in_valid <= 1'b1;
		x_in     <= x;
		y_in     <= y;
		z_in     <= z;
		is_point <= pt;
		do
			@(posedge clk);
		while (in_stall);
		point_book.note_request(x, y, z, pt);
	endtask

	initial begin
		int waited;
		point_book = new();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// identity after reset: corners pass straight through, translation is zero
		push_request('0, '0, '0, 1'b1);
		push_request(C_MAX, C_MAX, C_MAX, 1'b1);
		push_request(C_MIN, C_MIN, C_MIN, 1'b0);
		push_request(C_MAX, C_MIN, CW'(1), 1'b1);
		push_request('1, '1, '1, 1'b0);
		push_request(CW'(256), CW'(512), CW'(768), 1'b1);

		// largest positive coefficients and translation: clipping upwards and downwards
		load_transform({3{16'h7fff}}, {3{16'h7fff}}, {3{16'h7fff}}, C_MAX, C_MAX, C_MAX);
		push_request(C_MAX, C_MAX, C_MAX, 1'b1);
		push_request(C_MIN, C_MIN, C_MIN, 1'b0);
		push_request('0, '0, '0, 1'b1);
		push_request(CW'(1), CW'(1), CW'(1), 1'b1);

		// most negative coefficients and translation
		load_transform({3{16'h8000}}, {3{16'h8000}}, {3{16'h8000}}, C_MIN, C_MIN, C_MIN);
		push_request(C_MAX, C_MAX, C_MAX, 1'b1);
		push_request(C_MIN, C_MIN, C_MIN, 1'b0);
		push_request('0, '0, '0, 1'b1);
		push_request('1, '0, '0, 1'b1);

		// smallest coefficient: rounding ties go towards plus infinity
		load_transform({3{16'h0001}}, {3{16'h0001}}, {3{16'h0001}}, '0, '0, '0);
		push_request(CW'(2048), CW'(2048), CW'(2048), 1'b0);
		push_request(-CW'(2048), -CW'(2048), -CW'(2048), 1'b0);
		push_request(-CW'(2049), CW'(2049), -CW'(6144), 1'b1);
		push_request(CW'(2047), -CW'(2047), CW'(4095), 1'b1);

		// random transforms, each with a random stream of points and vectors
		for (int ph = 0; ph < 6; ph++) begin
			load_transform({rand_coef(), rand_coef(), rand_coef()},
				{rand_coef(), rand_coef(), rand_coef()},
				{rand_coef(), rand_coef(), rand_coef()},
				rand_coord(), rand_coord(), rand_coord());
			repeat (250)
				push_request(rand_coord(), rand_coord(), rand_coord(), 1'($urandom));
		end

		// drain, then allow the pipeline depth for stray results
		in_valid <= 1'b0;
		waited = 0;
		while (point_book.pending() > 0 && waited < 4000) begin
			@(posedge clk);
			waited++;
		end
		repeat (NUM_STAGES + 4) @(posedge clk);
		if (point_book.pending() > 0) begin
			$error("%0d expected results never arrived", point_book.pending());
			point_book.errors++;
		end

		$display("covered %0d points and %0d direction vectors over %0d register settings",
			point_book.points, point_book.vectors, settings);
		$display("%0d results were clipped, %0d mismatches seen",
			point_book.clipped, point_book.errors);
		if (point_book.errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	// hard stop in case the handshake hangs
	initial begin
		#4000000;
		$display("Regression FAIL");
		$finish;
	end

endmodule

>>> files.f
rtl/apt_pkg.sv
rtl/apt_cfg_regs.sv
rtl/apt_row_pipe.sv
rtl/affine_point_transform_core.sv
tb/apt_tb_pkg.sv
tb/affine_point_transform_core_tb.sv
